// File: hw/rtl/stkt_pkg.sv
// Shared constants, types and helpers of the sorted tagged key table.
`default_nettype none
package stkt_pkg;

    // Table geometry
    localparam int MAX_KEYS = 64;
    localparam int MAX_TAGS = 8;

    // Field widths
    localparam int KEYW = 64;
    localparam int TAGW = 64;
    localparam int OPW  = 3;
    localparam int POSW = 6;
    localparam int CCW  = 7;
    localparam int STW  = 2;

    // Derived index and counter widths
    localparam int KIW    = $clog2(MAX_KEYS);
    localparam int KCW    = $clog2(MAX_KEYS + 1);
    localparam int TIW    = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
    localparam int LCW    = $clog2(MAX_TAGS + 1);
    localparam int TDEPTH = MAX_KEYS * MAX_TAGS;
    localparam int TAW    = $clog2(TDEPTH);

    typedef logic [KIW-1:0] t_kidx;
    typedef logic [KCW-1:0] t_kcnt;
    typedef logic [LCW-1:0] t_lcnt;
    typedef logic [TAW-1:0] t_taddr;

    // Opcodes
    localparam logic [OPW-1:0] OP_PUT   = 3'd0;
    localparam logic [OPW-1:0] OP_RMKEY = 3'd1;
    localparam logic [OPW-1:0] OP_RDTAG = 3'd2;
    localparam logic [OPW-1:0] OP_SUPER = 3'd3;
    localparam logic [OPW-1:0] OP_EXACT = 3'd4;
    localparam logic [OPW-1:0] OP_RMTAG = 3'd5;
    localparam logic [OPW-1:0] OP_POS   = 3'd6;

    // Status codes
    localparam logic [STW-1:0] STS_OK    = 2'd0;
    localparam logic [STW-1:0] STS_NF    = 2'd1;
    localparam logic [STW-1:0] STS_TFULL = 2'd2;
    localparam logic [STW-1:0] STS_LFULL = 2'd3;

    // One result transaction
    typedef struct packed {
        logic [KEYW-1:0] key;
        logic [TAGW-1:0] tag;
        logic [POSW-1:0] pos;
        logic [CCW-1:0]  cc;
        logic            found;
        logic [STW-1:0]  status;
        logic            last;
    } t_res;

    function automatic t_res mk_res(input logic [KEYW-1:0] k, input logic [TAGW-1:0] tg,
                                    input logic [POSW-1:0] p, input logic [CCW-1:0] c,
                                    input logic f, input logic [STW-1:0] s, input logic l);
        t_res r;
        r.key    = k;
        r.tag    = tg;
        r.pos    = p;
        r.cc     = c;
        r.found  = f;
        r.status = s;
        r.last   = l;
        return r;
    endfunction

    // Flat tag store address of tag slot t of a row
    function automatic t_taddr tag_addr(input t_kidx row, input t_lcnt t);
        return t_taddr'(int'(row) * MAX_TAGS + int'(t));
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sorted_tagged_key_table.sv
// Sorted tagged key table: sequencer over key, tag-count and tag RAMs.
// Keys are kept in ascending order with a sorted tag list per entry. A non-final
// list element is buffered while the sequencer stays idle. Key lookups are a
// binary search, each step reading the midpoint key and then comparing it; an
// insert or key removal then moves every following row, one row at a time;
// writing a tag list writes one tag after another; reading tags gives one
// result per cycle while the output register is free. Queries and tag removal
// visit every entry. Each store has one read port, which the sequencer shares.
// A result may wait in the output register while the next transaction is taken.
`default_nettype none
module sorted_tagged_key_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [63:0] i_key,
    input  wire logic [63:0] i_tag,
    input  wire logic        i_has_tag,
    input  wire logic        i_list_end,
    input  wire logic [5:0]  i_position,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_out_key,
    output logic [63:0]      o_out_tag,
    output logic [5:0]       o_out_position,
    output logic [6:0]       o_change_count,
    output logic             o_found,
    output logic [1:0]       o_status,
    output logic             o_run_end
);

    localparam int MT = stkt_pkg::MAX_TAGS;

    // Sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_EMIT  = 5'd1;
    localparam logic [4:0] S_SRD   = 5'd2;
    localparam logic [4:0] S_SCMP  = 5'd3;
    localparam logic [4:0] S_SHIFT = 5'd4;
    localparam logic [4:0] S_CP    = 5'd5;
    localparam logic [4:0] S_WRT   = 5'd6;
    localparam logic [4:0] S_RCNT  = 5'd7;
    localparam logic [4:0] S_RCNTW = 5'd8;
    localparam logic [4:0] S_RTAGW = 5'd9;
    localparam logic [4:0] S_QRD   = 5'd10;
    localparam logic [4:0] S_QCNT  = 5'd11;
    localparam logic [4:0] S_QTAG  = 5'd12;
    localparam logic [4:0] S_QEVAL = 5'd13;
    localparam logic [4:0] S_XRD   = 5'd14;
    localparam logic [4:0] S_XCNT  = 5'd15;
    localparam logic [4:0] S_XTAG  = 5'd16;
    localparam logic [4:0] S_POS   = 5'd17;

    // Control registers
    logic [4:0]           r_state, n_state;
    stkt_pkg::t_kcnt      r_ecnt, n_ecnt;
    stkt_pkg::t_lcnt      r_lcnt, n_lcnt;
    stkt_pkg::t_lcnt      r_raw, n_raw;
    logic                 r_ovf, n_ovf;
    logic                 r_lop, n_lop;
    logic                 r_ovalid, n_ovalid;

    // Working registers
    logic [2:0]           r_op, n_op;
    logic [63:0]          r_key, n_key;
    logic [63:0]          r_tag, n_tag;
    logic [5:0]           r_pos, n_pos;
    logic [63:0]          r_list [MT];
    logic [63:0]          n_list [MT];
    stkt_pkg::t_kcnt      r_lo, n_lo;
    stkt_pkg::t_kcnt      r_hi, n_hi;
    stkt_pkg::t_kidx      r_mid, n_mid;
    logic                 r_hit, n_hit;
    stkt_pkg::t_kcnt      r_row, n_row;
    stkt_pkg::t_lcnt      r_t, n_t;
    stkt_pkg::t_lcnt      r_w, n_w;
    stkt_pkg::t_lcnt      r_cnt, n_cnt;
    stkt_pkg::t_kcnt      r_i, n_i;
    stkt_pkg::t_kcnt      r_cc, n_cc;
    logic [MT-1:0]        r_mask, n_mask;
    logic                 r_eq, n_eq;
    logic [63:0]          r_qkey, n_qkey;
    logic                 r_pend, n_pend;
    logic [63:0]          r_pkey, n_pkey;
    stkt_pkg::t_res       r_res, n_res;
    stkt_pkg::t_res       r_out;

    // Output load
    logic                 n_ld;
    stkt_pkg::t_res       n_ld_res;
    logic                 out_free;

    // Memory ports
    logic                  key_we, key_re;
    stkt_pkg::t_kidx       key_waddr, key_raddr;
    logic [63:0]           key_wdata, key_rdata;
    logic                  cnt_we, cnt_re;
    stkt_pkg::t_kidx       cnt_waddr, cnt_raddr;
    stkt_pkg::t_lcnt       cnt_wdata, cnt_rdata;
    logic                  tag_we, tag_re;
    stkt_pkg::t_taddr      tag_waddr, tag_raddr;
    logic [63:0]           tag_wdata, tag_rdata;

    // Helpers
    logic [stkt_pkg::KCW:0] mid_sum;
    stkt_pkg::t_kidx        mid;
    stkt_pkg::t_kidx        cp_src, cp_dst;
    stkt_pkg::t_lcnt        ins_p, t_nxt;
    logic                   ins_dup, ovf_now;
    logic [MT-1:0]          lmask, tag_hit;
    logic                   q_match;

    stkt_ram #(.WIDTH(64), .DEPTH(stkt_pkg::MAX_KEYS)) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(key_waddr),
        .i_wdata(key_wdata),
        .i_re   (key_re),
        .i_raddr(key_raddr),
        .o_rdata(key_rdata)
    );

    stkt_ram #(.WIDTH(stkt_pkg::LCW), .DEPTH(stkt_pkg::MAX_KEYS)) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (cnt_we),
        .i_waddr(cnt_waddr),
        .i_wdata(cnt_wdata),
        .i_re   (cnt_re),
        .i_raddr(cnt_raddr),
        .o_rdata(cnt_rdata)
    );

    stkt_ram #(.WIDTH(64), .DEPTH(stkt_pkg::TDEPTH)) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (tag_we),
        .i_waddr(tag_waddr),
        .i_wdata(tag_wdata),
        .i_re   (tag_re),
        .i_raddr(tag_raddr),
        .o_rdata(tag_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_ovalid || i_out_ready;

    // Ports from the output register
    assign o_out_valid    = r_ovalid;
    assign o_out_key      = r_out.key;
    assign o_out_tag      = r_out.tag;
    assign o_out_position = r_out.pos;
    assign o_change_count = r_out.cc;
    assign o_found        = r_out.found;
    assign o_status       = r_out.status;
    assign o_run_end      = r_out.last;

    // Search midpoint and row copy addresses
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[stkt_pkg::KIW:1];
    assign cp_dst  = r_row[stkt_pkg::KIW-1:0];
    assign t_nxt   = r_t + stkt_pkg::t_lcnt'(1);

    always_comb begin
        stkt_pkg::t_kcnt src_c;
        src_c  = (r_op == stkt_pkg::OP_PUT) ? (r_row - stkt_pkg::t_kcnt'(1))
                                            : (r_row + stkt_pkg::t_kcnt'(1));
        cp_src = src_c[stkt_pkg::KIW-1:0];
    end

    // Sorted insert position, duplicate check, overflow and query match for the list buffer
    always_comb begin
        ins_p   = '0;
        ins_dup = 1'b0;
        for (int j = 0; j < MT; j++) begin
            lmask[j]   = (stkt_pkg::t_lcnt'(j) < r_lcnt);
            tag_hit[j] = (r_list[j] == tag_rdata);
            if (lmask[j] && (r_list[j] < i_tag)) begin
                ins_p = ins_p + stkt_pkg::t_lcnt'(1);
            end
            if (lmask[j] && (r_list[j] == i_tag)) begin
                ins_dup = 1'b1;
            end
        end
        ovf_now = r_ovf || (i_has_tag && (r_raw == stkt_pkg::t_lcnt'(MT)));
        if (r_op == stkt_pkg::OP_EXACT) begin
            q_match = r_eq && (r_cnt == r_lcnt);
        end else begin
            q_match = &(r_mask | ~lmask);
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_ecnt   = r_ecnt;
        n_lcnt   = r_lcnt;
        n_raw    = r_raw;
        n_ovf    = r_ovf;
        n_lop    = r_lop;
        n_op     = r_op;
        n_key    = r_key;
        n_tag    = r_tag;
        n_pos    = r_pos;
        n_list   = r_list;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_hit    = r_hit;
        n_row    = r_row;
        n_t      = r_t;
        n_w      = r_w;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_cc     = r_cc;
        n_mask   = r_mask;
        n_eq     = r_eq;
        n_qkey   = r_qkey;
        n_pend   = r_pend;
        n_pkey   = r_pkey;
        n_res    = r_res;
        n_ld     = 1'b0;
        n_ld_res = r_res;

        key_we    = 1'b0;
        key_waddr = r_lo[stkt_pkg::KIW-1:0];
        key_wdata = r_key;
        key_re    = 1'b0;
        key_raddr = mid;
        cnt_we    = 1'b0;
        cnt_waddr = r_lo[stkt_pkg::KIW-1:0];
        cnt_wdata = r_lcnt;
        cnt_re    = 1'b0;
        cnt_raddr = r_lo[stkt_pkg::KIW-1:0];
        tag_we    = 1'b0;
        tag_waddr = stkt_pkg::tag_addr(r_lo[stkt_pkg::KIW-1:0], r_t);
        tag_wdata = r_list[r_t[stkt_pkg::TIW-1:0]];
        tag_re    = 1'b0;
        tag_raddr = stkt_pkg::tag_addr(r_i[stkt_pkg::KIW-1:0], r_t);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_opcode;
                    n_key = i_key;
                    n_tag = i_tag;
                    n_pos = i_position;
                    n_lop = 1'b0;
                    n_lo  = '0;
                    n_hi  = r_ecnt;
                    n_hit = 1'b0;
                    n_i   = '0;
                    unique case (i_opcode)
                        stkt_pkg::OP_PUT, stkt_pkg::OP_SUPER, stkt_pkg::OP_EXACT: begin
                            // Buffer the tag in sorted order, duplicates dropped
                            if (i_has_tag) begin
                                if (r_raw == stkt_pkg::t_lcnt'(MT)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_raw = r_raw + stkt_pkg::t_lcnt'(1);
                                    if (!ins_dup) begin
                                        n_lcnt = r_lcnt + stkt_pkg::t_lcnt'(1);
                                        for (int j = 0; j < MT; j++) begin
                                            if (stkt_pkg::t_lcnt'(j) == ins_p) begin
                                                n_list[j] = i_tag;
                                            end else if (stkt_pkg::t_lcnt'(j) > ins_p) begin
                                                n_list[j] = r_list[(j > 0) ? j - 1 : 0];
                                            end
                                        end
                                    end
                                end
                            end
                            if (i_list_end) begin
                                n_lop  = 1'b1;
                                n_pend = 1'b0;
                                if (ovf_now) begin
                                    n_res = stkt_pkg::mk_res(
                                        (i_opcode == stkt_pkg::OP_PUT) ? i_key : 64'd0,
                                        64'd0, 6'd0, 7'd0, 1'b0, stkt_pkg::STS_LFULL, 1'b1);
                                    n_state = S_EMIT;
                                end else if (i_opcode == stkt_pkg::OP_PUT) begin
                                    n_state = S_SRD;
                                end else begin
                                    n_state = S_QRD;
                                end
                            end
                        end
                        stkt_pkg::OP_RMKEY, stkt_pkg::OP_RDTAG: begin
                            n_state = S_SRD;
                        end
                        stkt_pkg::OP_RMTAG: begin
                            n_cc    = '0;
                            n_state = S_XRD;
                        end
                        stkt_pkg::OP_POS: begin
                            if (7'(i_position) < 7'(r_ecnt)) begin
                                key_re    = 1'b1;
                                key_raddr = stkt_pkg::t_kidx'(i_position);
                                n_state   = S_POS;
                            end else begin
                                n_res = stkt_pkg::mk_res(64'd0, 64'd0, 6'd0, 7'd0, 1'b0,
                                                         stkt_pkg::STS_NF, 1'b1);
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Single final result, list cleared after a list operation
            S_EMIT: begin
                if (out_free) begin
                    n_ld     = 1'b1;
                    n_ld_res = r_res;
                    n_state  = S_IDLE;
                    if (r_lop) begin
                        n_lcnt = '0;
                        n_raw  = '0;
                        n_ovf  = 1'b0;
                        n_lop  = 1'b0;
                    end
                end
            end

            // Binary search: issue a read of the midpoint or dispatch
            S_SRD: begin
                if (r_lo < r_hi) begin
                    key_re  = 1'b1;
                    n_mid   = mid;
                    n_state = S_SCMP;
                end else begin
                    n_t = '0;
                    unique case (r_op)
                        stkt_pkg::OP_PUT: begin
                            if (r_hit) begin
                                n_state = S_WRT;
                            end else if (r_ecnt == stkt_pkg::t_kcnt'(stkt_pkg::MAX_KEYS)) begin
                                n_res = stkt_pkg::mk_res(r_key, 64'd0, 6'd0, 7'd0, 1'b0,
                                                         stkt_pkg::STS_TFULL, 1'b1);
                                n_state = S_EMIT;
                            end else begin
                                n_row   = r_ecnt;
                                n_state = S_SHIFT;
                            end
                        end
                        stkt_pkg::OP_RMKEY, stkt_pkg::OP_RDTAG: begin
                            if (!r_hit) begin
                                n_res = stkt_pkg::mk_res(r_key, 64'd0, 6'd0, 7'd0, 1'b0,
                                                         stkt_pkg::STS_NF, 1'b1);
                                n_state = S_EMIT;
                            end else if (r_op == stkt_pkg::OP_RMKEY) begin
                                n_row   = r_lo;
                                n_state = S_SHIFT;
                            end else begin
                                n_state = S_RCNT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCMP: begin
                if (key_rdata < r_key) begin
                    n_lo = stkt_pkg::t_kcnt'(r_mid) + stkt_pkg::t_kcnt'(1);
                end else begin
                    n_hi = stkt_pkg::t_kcnt'(r_mid);
                end
                if (key_rdata == r_key) begin
                    n_hit = 1'b1;
                end
                n_state = S_SRD;
            end

            // Row moves: up for insert, down for removal
            S_SHIFT: begin
                n_t = '0;
                if (r_op == stkt_pkg::OP_PUT) begin
                    if (r_row > r_lo) begin
                        n_state = S_CP;
                    end else begin
                        n_state = S_WRT;
                    end
                end else begin
                    if ((r_row + stkt_pkg::t_kcnt'(1)) < r_ecnt) begin
                        n_state = S_CP;
                    end else begin
                        n_ecnt = r_ecnt - stkt_pkg::t_kcnt'(1);
                        n_res  = stkt_pkg::mk_res(r_key, 64'd0, 6'(r_lo), 7'd0, 1'b1,
                                                  stkt_pkg::STS_OK, 1'b1);
                        n_state = S_EMIT;
                    end
                end
            end

            // Copy one row, tag reads pipelined one ahead of the writes
            S_CP: begin
                if (r_t < stkt_pkg::t_lcnt'(MT)) begin
                    tag_re    = 1'b1;
                    tag_raddr = stkt_pkg::tag_addr(cp_src, r_t);
                end
                if (r_t == '0) begin
                    key_re    = 1'b1;
                    key_raddr = cp_src;
                    cnt_re    = 1'b1;
                    cnt_raddr = cp_src;
                end else begin
                    tag_we    = 1'b1;
                    tag_waddr = stkt_pkg::tag_addr(cp_dst, r_t - stkt_pkg::t_lcnt'(1));
                    tag_wdata = tag_rdata;
                end
                if (r_t == stkt_pkg::t_lcnt'(1)) begin
                    key_we    = 1'b1;
                    key_waddr = cp_dst;
                    key_wdata = key_rdata;
                    cnt_we    = 1'b1;
                    cnt_waddr = cp_dst;
                    cnt_wdata = cnt_rdata;
                end
                if (r_t == stkt_pkg::t_lcnt'(MT)) begin
                    n_row   = (r_op == stkt_pkg::OP_PUT) ? (r_row - stkt_pkg::t_kcnt'(1))
                                                         : (r_row + stkt_pkg::t_kcnt'(1));
                    n_state = S_SHIFT;
                end else begin
                    n_t = t_nxt;
                end
            end

            // Write key, count and buffered tags of the put entry
            S_WRT: begin
                key_we = 1'b1;
                cnt_we = 1'b1;
                if (r_t < r_lcnt) begin
                    tag_we = 1'b1;
                end
                n_t = t_nxt;
                if (t_nxt >= r_lcnt) begin
                    if (!r_hit) begin
                        n_ecnt = r_ecnt + stkt_pkg::t_kcnt'(1);
                    end
                    n_res = stkt_pkg::mk_res(r_key, 64'd0, 6'(r_lo), 7'd0, r_hit,
                                             stkt_pkg::STS_OK, 1'b1);
                    n_state = S_EMIT;
                end
            end

            // Read back the tags of a key
            S_RCNT: begin
                cnt_re    = 1'b1;
                tag_re    = 1'b1;
                tag_raddr = stkt_pkg::tag_addr(r_lo[stkt_pkg::KIW-1:0], '0);
                n_state   = S_RCNTW;
            end

            S_RCNTW: begin
                n_cnt = cnt_rdata;
                n_t   = '0;
                if (cnt_rdata == '0) begin
                    n_res = stkt_pkg::mk_res(r_key, 64'd0, 6'(r_lo), 7'd0, 1'b1,
                                             stkt_pkg::STS_OK, 1'b1);
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RTAGW;
                end
            end

            S_RTAGW: begin
                if (out_free) begin
                    n_ld     = 1'b1;
                    n_ld_res = stkt_pkg::mk_res(r_key, tag_rdata, 6'(r_lo), 7'd0, 1'b1,
                                                stkt_pkg::STS_OK, t_nxt == r_cnt);
                    n_t      = t_nxt;
                    if (t_nxt == r_cnt) begin
                        n_state = S_IDLE;
                    end else begin
                        tag_re    = 1'b1;
                        tag_raddr = stkt_pkg::tag_addr(r_lo[stkt_pkg::KIW-1:0], t_nxt);
                    end
                end
            end

            // Query scan over all entries
            S_QRD: begin
                if (r_i < r_ecnt) begin
                    key_re    = 1'b1;
                    key_raddr = r_i[stkt_pkg::KIW-1:0];
                    cnt_re    = 1'b1;
                    cnt_raddr = r_i[stkt_pkg::KIW-1:0];
                    tag_re    = 1'b1;
                    tag_raddr = stkt_pkg::tag_addr(r_i[stkt_pkg::KIW-1:0], '0);
                    n_t       = '0;
                    n_mask    = '0;
                    n_eq      = 1'b1;
                    n_state   = S_QCNT;
                end else begin
                    if (r_pend) begin
                        n_res = stkt_pkg::mk_res(r_pkey, 64'd0, 6'd0, 7'd0, 1'b1,
                                                 stkt_pkg::STS_OK, 1'b1);
                    end else begin
                        n_res = stkt_pkg::mk_res(64'd0, 64'd0, 6'd0, 7'd0, 1'b0,
                                                 stkt_pkg::STS_NF, 1'b1);
                    end
                    n_state = S_EMIT;
                end
            end

            S_QCNT: begin
                n_cnt   = cnt_rdata;
                n_qkey  = key_rdata;
                n_state = S_QTAG;
            end

            S_QTAG: begin
                if (r_t < r_cnt) begin
                    n_mask = r_mask | tag_hit;
                    if ((r_t >= r_lcnt) || (r_list[r_t[stkt_pkg::TIW-1:0]] != tag_rdata)) begin
                        n_eq = 1'b0;
                    end
                    if (t_nxt < r_cnt) begin
                        tag_re    = 1'b1;
                        tag_raddr = stkt_pkg::tag_addr(r_i[stkt_pkg::KIW-1:0], t_nxt);
                    end
                    n_t = t_nxt;
                end else begin
                    n_state = S_QEVAL;
                end
            end

            // A match is held back until the next one is found so the last one can carry run end
            S_QEVAL: begin
                if (!(q_match && r_pend && !out_free)) begin
                    if (q_match) begin
                        if (r_pend) begin
                            n_ld     = 1'b1;
                            n_ld_res = stkt_pkg::mk_res(r_pkey, 64'd0, 6'd0, 7'd0, 1'b1,
                                                        stkt_pkg::STS_OK, 1'b0);
                        end
                        n_pend = 1'b1;
                        n_pkey = r_qkey;
                    end
                    n_i     = r_i + stkt_pkg::t_kcnt'(1);
                    n_state = S_QRD;
                end
            end

            // Tag removal scan, compacting each row in place
            S_XRD: begin
                if (r_i < r_ecnt) begin
                    cnt_re    = 1'b1;
                    cnt_raddr = r_i[stkt_pkg::KIW-1:0];
                    tag_re    = 1'b1;
                    tag_raddr = stkt_pkg::tag_addr(r_i[stkt_pkg::KIW-1:0], '0);
                    n_t       = '0;
                    n_w       = '0;
                    n_state   = S_XCNT;
                end else begin
                    n_res = stkt_pkg::mk_res(64'd0, 64'd0, 6'd0, 7'(r_cc), r_cc != '0,
                                             stkt_pkg::STS_OK, 1'b1);
                    n_state = S_EMIT;
                end
            end

            S_XCNT: begin
                n_cnt   = cnt_rdata;
                n_state = S_XTAG;
            end

            S_XTAG: begin
                if (r_t < r_cnt) begin
                    if (tag_rdata != r_tag) begin
                        tag_we    = 1'b1;
                        tag_waddr = stkt_pkg::tag_addr(r_i[stkt_pkg::KIW-1:0], r_w);
                        tag_wdata = tag_rdata;
                        n_w       = r_w + stkt_pkg::t_lcnt'(1);
                    end
                    if (t_nxt < r_cnt) begin
                        tag_re    = 1'b1;
                        tag_raddr = stkt_pkg::tag_addr(r_i[stkt_pkg::KIW-1:0], t_nxt);
                    end
                    n_t = t_nxt;
                end else begin
                    if (r_w != r_cnt) begin
                        cnt_we    = 1'b1;
                        cnt_waddr = r_i[stkt_pkg::KIW-1:0];
                        cnt_wdata = r_w;
                        n_cc      = r_cc + stkt_pkg::t_kcnt'(1);
                    end
                    n_i     = r_i + stkt_pkg::t_kcnt'(1);
                    n_state = S_XRD;
                end
            end

            S_POS: begin
                n_res = stkt_pkg::mk_res(key_rdata, 64'd0, r_pos, 7'd0, 1'b1,
                                         stkt_pkg::STS_OK, 1'b1);
                n_state = S_EMIT;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Output valid
        if (n_ld) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ecnt   <= '0;
            r_lcnt   <= '0;
            r_raw    <= '0;
            r_ovf    <= 1'b0;
            r_lop    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ecnt   <= n_ecnt;
            r_lcnt   <= n_lcnt;
            r_raw    <= n_raw;
            r_ovf    <= n_ovf;
            r_lop    <= n_lop;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_tag  <= n_tag;
        r_pos  <= n_pos;
        r_list <= n_list;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_hit  <= n_hit;
        r_row  <= n_row;
        r_t    <= n_t;
        r_w    <= n_w;
        r_cnt  <= n_cnt;
        r_i    <= n_i;
        r_cc   <= n_cc;
        r_mask <= n_mask;
        r_eq   <= n_eq;
        r_qkey <= n_qkey;
        r_pend <= n_pend;
        r_pkey <= n_pkey;
        r_res  <= n_res;
        if (n_ld) begin
            r_out <= n_ld_res;
        end
    end

    // Checks
    a_ecnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= stkt_pkg::t_kcnt'(stkt_pkg::MAX_KEYS))
        else $error("entry count above table size");

    a_list_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lcnt <= r_raw) && (r_raw <= stkt_pkg::t_lcnt'(MT)))
        else $error("list counts inconsistent");

    a_ld_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_ld |-> out_free)
        else $error("result loaded over a pending transaction");

    a_cp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CP) |-> (r_t <= stkt_pkg::t_lcnt'(MT)))
        else $error("row copy counter out of range");

    a_ld_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_ld && n_ld_res.last) |=> (r_state == S_IDLE))
        else $error("final result given while sequence continues");

endmodule
`default_nettype wire

// File: hw/rtl/stkt_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module stkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: verif/sorted_tagged_key_table_tb.sv
// Self-checking testbench for the sorted tagged key table: directed and random transactions.
`default_nettype none
module sorted_tagged_key_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_opcode = '0;
    logic [63:0] i_key = '0;
    logic [63:0] i_tag = '0;
    logic        i_has_tag = 1'b0;
    logic        i_list_end = 1'b0;
    logic [5:0]  i_position = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_out_key;
    logic [63:0] o_out_tag;
    logic [5:0]  o_out_position;
    logic [6:0]  o_change_count;
    logic        o_found;
    logic [1:0]  o_status;
    logic        o_run_end;

    sorted_tagged_key_table i_dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Predictor state: sorted table and pending tag list
    logic [63:0] tbl_key [stkt_pkg::MAX_KEYS];
    logic [63:0] tbl_tag [stkt_pkg::MAX_KEYS][stkt_pkg::MAX_TAGS];
    int          tbl_ntag [stkt_pkg::MAX_KEYS];
    int          n_entries = 0;
    logic [63:0] pend_list [stkt_pkg::MAX_TAGS];
    int          pend_count = 0;
    bit          pend_overflow = 0;

    stkt_pkg::t_res expected_results[$];
    int   error_count = 0;
    bit   quiet_mode = 0;
    bit   tb_done = 0;
    logic [63:0] used_keys[$];
    logic [63:0] used_tags[$];

    function automatic void push_result(logic [63:0] k, logic [63:0] tg, int p, int c,
                                        bit f, logic [1:0] s);
        expected_results.push_back(stkt_pkg::mk_res(k, tg, p[5:0], c[6:0], f, s, 1'b0));
    endfunction

    function automatic void mark_last();
        stkt_pkg::t_res r;
        r = expected_results[$];
        r.last = 1'b1;
        expected_results[$] = r;
    endfunction

    function automatic int find_slot(logic [63:0] k);
        int i;
        i = 0;
        while (i < n_entries && tbl_key[i] < k) i++;
        return i;
    endfunction

    // Sort the pending list and drop duplicates
    function automatic void normalize_list();
        logic [63:0] v;
        int j, n;
        for (int i = 1; i < pend_count; i++) begin
            v = pend_list[i];
            j = i;
            while (j > 0 && pend_list[j-1] > v) begin
                pend_list[j] = pend_list[j-1];
                j--;
            end
            pend_list[j] = v;
        end
        n = 0;
        for (int i = 0; i < pend_count; i++)
            if (n == 0 || pend_list[n-1] != pend_list[i]) begin
                pend_list[n] = pend_list[i];
                n++;
            end
        pend_count = n;
    endfunction

    function automatic bit entry_matches(int e, bit exact);
        bit hit;
        if (exact) begin
            if (tbl_ntag[e] != pend_count) return 0;
            for (int t = 0; t < pend_count; t++)
                if (tbl_tag[e][t] != pend_list[t]) return 0;
            return 1;
        end
        for (int t = 0; t < pend_count; t++) begin
            hit = 0;
            for (int u = 0; u < tbl_ntag[e]; u++) if (tbl_tag[e][u] == pend_list[t]) hit = 1;
            if (!hit) return 0;
        end
        return 1;
    endfunction

    function automatic void copy_entry(int d, int s);
        tbl_key[d] = tbl_key[s];
        tbl_ntag[d] = tbl_ntag[s];
        for (int t = 0; t < stkt_pkg::MAX_TAGS; t++) tbl_tag[d][t] = tbl_tag[s][t];
    endfunction

    // Work out the results one transaction causes, updating the table model
    function automatic void predict_table(logic [2:0] op, logic [63:0] k, logic [63:0] tg,
                                          bit has, bit lst, logic [5:0] p);
        int idx, n, cc, w, c;
        n = expected_results.size();
        case (op)
            stkt_pkg::OP_PUT, stkt_pkg::OP_SUPER, stkt_pkg::OP_EXACT: begin
                if (has) begin
                    if (pend_count < stkt_pkg::MAX_TAGS) begin
                        pend_list[pend_count] = tg;
                        pend_count++;
                    end else pend_overflow = 1;
                end
                if (!lst) return;
                if (pend_overflow) begin
                    push_result(op == stkt_pkg::OP_PUT ? k : 64'd0, 0, 0, 0, 0,
                                stkt_pkg::STS_LFULL);
                end else begin
                    normalize_list();
                    if (op == stkt_pkg::OP_PUT) begin
                        idx = find_slot(k);
                        if (idx < n_entries && tbl_key[idx] == k) begin
                            for (int t = 0; t < pend_count; t++) tbl_tag[idx][t] = pend_list[t];
                            tbl_ntag[idx] = pend_count;
                            push_result(k, 0, idx, 0, 1, stkt_pkg::STS_OK);
                        end else if (n_entries >= stkt_pkg::MAX_KEYS) begin
                            push_result(k, 0, 0, 0, 0, stkt_pkg::STS_TFULL);
                        end else begin
                            for (int i = n_entries; i > idx; i--) copy_entry(i, i - 1);
                            tbl_key[idx] = k;
                            for (int t = 0; t < pend_count; t++) tbl_tag[idx][t] = pend_list[t];
                            tbl_ntag[idx] = pend_count;
                            n_entries++;
                            push_result(k, 0, idx, 0, 0, stkt_pkg::STS_OK);
                        end
                    end else begin
                        for (int i = 0; i < n_entries; i++)
                            if (entry_matches(i, op == stkt_pkg::OP_EXACT))
                                push_result(tbl_key[i], 0, 0, 0, 1, stkt_pkg::STS_OK);
                        if (expected_results.size() == n)
                            push_result(0, 0, 0, 0, 0, stkt_pkg::STS_NF);
                    end
                end
                pend_count = 0;
                pend_overflow = 0;
            end
            stkt_pkg::OP_RMKEY: begin
                idx = find_slot(k);
                if (idx < n_entries && tbl_key[idx] == k) begin
                    for (int i = idx; i + 1 < n_entries; i++) copy_entry(i, i + 1);
                    n_entries--;
                    push_result(k, 0, idx, 0, 1, stkt_pkg::STS_OK);
                end else push_result(k, 0, 0, 0, 0, stkt_pkg::STS_NF);
            end
            stkt_pkg::OP_RDTAG: begin
                idx = find_slot(k);
                if (idx < n_entries && tbl_key[idx] == k) begin
                    for (int t = 0; t < tbl_ntag[idx]; t++)
                        push_result(k, tbl_tag[idx][t], idx, 0, 1, stkt_pkg::STS_OK);
                    if (tbl_ntag[idx] == 0) push_result(k, 0, idx, 0, 1, stkt_pkg::STS_OK);
                end else push_result(k, 0, 0, 0, 0, stkt_pkg::STS_NF);
            end
            stkt_pkg::OP_RMTAG: begin
                cc = 0;
                for (int i = 0; i < n_entries; i++) begin
                    c = tbl_ntag[i];
                    w = 0;
                    for (int t = 0; t < c; t++)
                        if (tbl_tag[i][t] != tg) begin
                            tbl_tag[i][w] = tbl_tag[i][t];
                            w++;
                        end
                    if (w != c) begin
                        tbl_ntag[i] = w;
                        cc++;
                    end
                end
                push_result(0, 0, 0, cc, cc > 0, stkt_pkg::STS_OK);
            end
            stkt_pkg::OP_POS: begin
                if (p < n_entries) push_result(tbl_key[p], 0, p, 0, 1, stkt_pkg::STS_OK);
                else push_result(0, 0, 0, 0, 0, stkt_pkg::STS_NF);
            end
            default: return;
        endcase
        mark_last();
    endfunction

    // Drive one transaction; sometimes a random gap before it unless quiet
    task automatic send_item(logic [2:0] op, logic [63:0] k, logic [63:0] tg,
                             bit has, bit lst, logic [5:0] p);
        int gap;
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_key      <= k;
        i_tag      <= tg;
        i_has_tag  <= has;
        i_list_end <= lst;
        i_position <= p;
        do @(posedge i_clk); while (!o_in_ready);
        predict_table(op, k, tg, has, lst, p);
        @(negedge i_clk);
    endtask

    task automatic send_list(logic [2:0] op, logic [63:0] k, logic [63:0] tags[$]);
        if (tags.size() == 0) send_item(op, k, 64'($urandom), 0, 1, 0);
        for (int i = 0; i < tags.size(); i++)
            send_item(op, k, tags[i], 1, i == tags.size() - 1, 6'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Result checker and output stall generator
    int quiet_cycles = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        stkt_pkg::t_res exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result key=%h", o_out_key);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out_key !== exp_r.key) begin
                    $error("out_key exp %h got %h", exp_r.key, o_out_key); error_count++;
                end
                if (o_out_tag !== exp_r.tag) begin
                    $error("out_tag exp %h got %h", exp_r.tag, o_out_tag); error_count++;
                end
                if (o_out_position !== exp_r.pos) begin
                    $error("out_position exp %0d got %0d", exp_r.pos, o_out_position);
                    error_count++;
                end
                if (o_change_count !== exp_r.cc) begin
                    $error("change_count exp %0d got %0d", exp_r.cc, o_change_count);
                    error_count++;
                end
                if (o_found !== exp_r.found) begin
                    $error("found exp %0d got %0d", exp_r.found, o_found); error_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, o_status); error_count++;
                end
                if (o_run_end !== exp_r.last) begin
                    $error("run_end exp %0d got %0d", exp_r.last, o_run_end); error_count++;
                end
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_out_ready <= 1'b0;
        end else i_out_ready <= 1'b1;
    end

    // Watchdog on cycles with no transaction
    initial begin
        wait (i_rst_n);
        while (!tb_done && quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        if (!tb_done) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] pick_key();
        logic [63:0] k;
        if (used_keys.size() != 0 && $urandom_range(0, 2) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        k = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 40));
        used_keys.push_back(k);
        return k;
    endfunction

    function automatic logic [63:0] pick_tag();
        logic [63:0] t;
        if (used_tags.size() != 0 && $urandom_range(0, 2) != 0)
            return used_tags[$urandom_range(0, used_tags.size() - 1)];
        t = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 12));
        used_tags.push_back(t);
        return t;
    endfunction

    // Directed: extremes, every opcode, special cases
    task automatic test_directed();
        logic [63:0] l[$];
        send_item(stkt_pkg::OP_RDTAG, 64'd5, 0, 0, 0, 0);      // missing key read
        send_item(stkt_pkg::OP_RMKEY, '1, 0, 0, 0, 0);         // missing key remove
        send_item(stkt_pkg::OP_POS, 0, 0, 0, 0, 6'd63);        // position beyond table
        l = '{'1, 64'd3, 64'd3, 64'd0};                        // duplicates, unsorted
        send_list(stkt_pkg::OP_PUT, '1, l);
        l = {};
        send_list(stkt_pkg::OP_PUT, 64'd0, l);                 // entry with no tags
        send_item(stkt_pkg::OP_RDTAG, 64'd0, 0, 0, 0, 0);
        send_item(stkt_pkg::OP_RDTAG, '1, 0, 0, 0, 0);
        l = '{64'd3, '1};
        send_list(stkt_pkg::OP_PUT, 64'h5555_aaaa_5555_aaaa, l);
        send_list(stkt_pkg::OP_SUPER, 0, l);
        send_list(stkt_pkg::OP_EXACT, 0, l);
        l = '{64'd99};
        send_list(stkt_pkg::OP_SUPER, 0, l);                   // query without matches
        l = {};
        send_list(stkt_pkg::OP_EXACT, 0, l);                   // exact on empty list
        send_item(stkt_pkg::OP_PUT, 64'd7, 64'd1, 1, 0, 0);    // mixed opcodes in one list
        send_item(stkt_pkg::OP_EXACT, 64'd7, 64'd3, 1, 1, 0);
        l = '{1, 2, 3, 4, 5, 6, 7, 8, 9};                      // list overflow
        send_list(stkt_pkg::OP_PUT, 64'd9, l);
        send_list(stkt_pkg::OP_SUPER, 64'd9, l);
        send_item(stkt_pkg::OP_RMTAG, 0, 64'd3, 1, 0, 0);
        send_item(stkt_pkg::OP_RMTAG, 0, 64'd1234, 0, 0, 0);
        send_item(stkt_pkg::OP_POS, 0, 0, 0, 0, 6'd0);
        send_item(3'd7, '1, '1, 1, 1, '1);                     // ignored opcode
        send_item(stkt_pkg::OP_RMKEY, '1, 0, 0, 0, 0);
        send_item(stkt_pkg::OP_POS, 0, 0, 0, 0, 6'd1);
    endtask

    // Pause the sender until nothing is pending
    task automatic test_drain_pause();
        wait_drained();
    endtask

    // Fill the table to capacity, try one more insert, then query and remove entries
    task automatic test_table_full();
        logic [63:0] l[$];
        for (int i = 0; n_entries < stkt_pkg::MAX_KEYS; i++) begin
            l = '{64'($urandom_range(0, 5))};
            send_list(stkt_pkg::OP_PUT, 64'h100 + 64'(i * 3), l);
        end
        l = {};
        send_list(stkt_pkg::OP_PUT, 64'h101, l);
        send_list(stkt_pkg::OP_PUT, 64'h100, l);               // replace still works
        l = '{64'd2};
        send_list(stkt_pkg::OP_SUPER, 0, l);
        send_item(stkt_pkg::OP_POS, 0, 0, 0, 0, 6'd63);
        send_item(stkt_pkg::OP_RMTAG, 0, 64'd2, 1, 0, 0);
        for (int i = 0; i < 40; i++)
            send_item(stkt_pkg::OP_RMKEY, 64'h100 + 64'(i * 3), 0, 0, 0, 0);
    endtask

    // Random mix, mostly well-formed lists
    task automatic test_random(int count);
        logic [63:0] l[$];
        int sel, len;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                len = $urandom_range(0, 100) < 5 ? 9 : $urandom_range(0, 4);
                l = {};
                for (int j = 0; j < len; j++) l.push_back(pick_tag());
                send_list(sel < 25 ? stkt_pkg::OP_PUT :
                          (sel < 35 ? stkt_pkg::OP_SUPER : stkt_pkg::OP_EXACT), pick_key(), l);
            end else if (sel < 55)
                send_item(stkt_pkg::OP_RMKEY, pick_key(), {$urandom, $urandom}, 0, 0, 0);
            else if (sel < 70)
                send_item(stkt_pkg::OP_RDTAG, pick_key(), {$urandom, $urandom}, 1, 1, 0);
            else if (sel < 77)
                send_item(stkt_pkg::OP_RMTAG, {$urandom, $urandom}, pick_tag(), 1, 0, 0);
            else if (sel < 90)
                send_item(stkt_pkg::OP_POS, {$urandom, $urandom}, 0, 0, 0, 6'($urandom));
            else if (sel < 95)
                send_item($urandom_range(0, 1) ? 3'd7 : stkt_pkg::OP_PUT,
                          {$urandom, $urandom}, pick_tag(), 1, 0, 6'($urandom));
            else send_item(stkt_pkg::OP_SUPER, pick_key(), 0, 0, 1, 0);
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_drain_pause();
        test_random(25);
        test_table_full();
        test_random(20);
        quiet_mode = 1;
        test_random(15);
        wait_drained();
        tb_done = 1;
        if (error_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

// File: sorted_tagged_key_table.f
hw/rtl/stkt_pkg.sv
hw/rtl/stkt_ram.sv
hw/rtl/sorted_tagged_key_table.sv
verif/sorted_tagged_key_table_tb.sv
